// ===== hw/rtl/plbq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_pkg
// Shared types and constants of the price-level book with best quote tracking.
// ----------------------------------------------------------------------------
package plbq_pkg;

   localparam int DEF_PRICE_LEVELS = 128;
   localparam int DEF_INSTRUMENTS  = 8;

   localparam int PRICE_W = 7;
   localparam int VOL_W   = 31;
   localparam int INST_W  = 3;

   // Number of bitmap bits the level search looks at in one cycle.
   localparam int SCAN_CHUNK = 8;

   typedef enum logic [1:0] {
      KIND_NULL   = 2'd0,
      KIND_REPORT = 2'd1,
      KIND_UPDATE = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               side;
      logic [INST_W-1:0]  instrument;
      logic [PRICE_W-1:0] price;
      logic [VOL_W-1:0]   volume;
   } cmd_type;

   typedef struct packed {
      logic [PRICE_W-1:0] best_bid_price;
      logic [VOL_W-1:0]   best_bid_volume;
      logic               ask_empty;
      logic [PRICE_W-1:0] best_ask_price;
      logic [VOL_W-1:0]   best_ask_volume;
   } rsp_type;

endpackage

// ===== hw/rtl/plbq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_front
// Accepts requests, classifies them and hands them to the command queue.
// ----------------------------------------------------------------------------
module plbq_front import plbq_pkg::*; #(
   parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
   parameter int INSTRUMENTS  = DEF_INSTRUMENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic [INST_W-1:0]  req_instrument,
   input  logic [PRICE_W-1:0] req_price,
   input  logic [VOL_W-1:0]   req_volume,
   input  logic               clearing,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd
);

   logic    valid_ff, valid_in;
   cmd_type cmd_ff;
   cmd_type cmd_in;
   logic    accept;
   logic    inst_ok;
   logic    price_ok;

   assign q_push   = valid_ff && !q_full;
   assign q_cmd    = cmd_ff;
   assign req_full = clearing || (valid_ff && q_full);
   assign accept   = req_push && !req_full;

   assign inst_ok  = 32'(req_instrument) < INSTRUMENTS;
   assign price_ok = (req_price != '0) && (32'(req_price) < PRICE_LEVELS);

   always_comb begin
      cmd_in.side       = req_mode;
      cmd_in.instrument = req_instrument;
      cmd_in.price      = req_price;
      cmd_in.volume     = req_volume;
      if (!inst_ok) begin
         cmd_in.kind = KIND_NULL;
      end else if (!price_ok) begin
         cmd_in.kind = KIND_REPORT;
      end else begin
         cmd_in.kind = KIND_UPDATE;
      end
   end

   assign valid_in = accept ? 1'b1 : (q_push ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// ===== hw/rtl/plbq_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_queue
// Two-entry command queue between the front and the back end.
// ----------------------------------------------------------------------------
module plbq_queue import plbq_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output cmd_type pop_cmd
);

   cmd_type    entry_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   assign full    = count_ff == 2'd2;
   assign valid   = count_ff != 2'd0;
   assign pop_cmd = entry_ff[rd_ff];

   always_comb begin
      wr_in    = push ? !wr_ff : wr_ff;
      rd_in    = pop ? !rd_ff : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/plbq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_back
// Executes book updates: volume store, occupancy bitmap, best quotes, the
// next-level search and the result register.
// ----------------------------------------------------------------------------
module plbq_back import plbq_pkg::*; #(
   parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
   parameter int INSTRUMENTS  = DEF_INSTRUMENTS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    q_valid,
   input  cmd_type q_cmd,
   output logic    q_pop,
   output logic    clearing,
   input  logic    rsp_pop,
   output logic    rsp_valid,
   output rsp_type rsp
);

   localparam int IX_W      = (INSTRUMENTS > 1) ? $clog2(INSTRUMENTS) : 1;
   localparam int LVL_W     = $clog2(PRICE_LEVELS);
   localparam int ROWS      = 2 * INSTRUMENTS;
   localparam int ROW_W     = IX_W + 1;
   localparam int VOL_DEPTH = INSTRUMENTS * 2 * (2 ** LVL_W);
   localparam int NCHUNK    = (PRICE_LEVELS + SCAN_CHUNK - 1) / SCAN_CHUNK;
   localparam int CH_W      = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
   localparam int PAD_W     = NCHUNK * SCAN_CHUNK;
   localparam int REC_W     = 1 + LVL_W + VOL_W;
   localparam logic [REC_W-1:0] REC_RESET = {1'b1, {(LVL_W + VOL_W){1'b0}}};

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_READ  = 5'b00100,
      ST_SCAN  = 5'b01000,
      ST_VOL   = 5'b10000
   } state_type;

   logic [VOL_W-1:0]        vol_mem [VOL_DEPTH];
   logic [PRICE_LEVELS-1:0] bmp_mem [ROWS];
   logic [REC_W-1:0]        bid_mem [INSTRUMENTS];
   logic [REC_W-1:0]        ask_mem [INSTRUMENTS];

   state_type state_ff, state_in;
   logic [ROW_W-1:0] clr_ff, clr_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;

   kind_type                kind_ff;
   logic                    side_ff;
   logic [IX_W-1:0]         inst_ff;
   logic [LVL_W-1:0]        lvl_ff;
   logic [VOL_W-1:0]        vol_ff;
   logic [PRICE_LEVELS-1:0] row_rd_ff;
   logic [REC_W-1:0]        bid_rd_ff;
   logic [REC_W-1:0]        ask_rd_ff;
   logic [PRICE_LEVELS-1:0] row_ff, row_in;
   logic [CH_W-1:0]         chunk_ff, chunk_in;
   logic [LVL_W-1:0]        found_ff, found_in;
   logic [VOL_W-1:0]        vol_rd_ff;

   logic [31:0]             q_inst32;
   logic [31:0]             q_lvl32;
   logic [IX_W-1:0]         q_inst;
   logic                    start;

   logic [PRICE_LEVELS-1:0] new_row;
   logic [REC_W-1:0]        cur;
   logic [LVL_W-1:0]        cur_lvl;
   logic                    vol_nz;
   logic                    take;
   logic                    rescan;
   logic [31:0]             lvl32;
   logic [31:0]             start_chunk32;

   logic [PAD_W-1:0]        row_pad;
   logic [SCAN_CHUNK-1:0]   chunk_bits;
   logic                    hit;
   logic [31:0]             hit_idx;
   logic [LVL_W-1:0]        hit_lvl;
   logic                    last_chunk;

   logic                    finish;
   logic                    best_we;
   logic [REC_W-1:0]        fin_rec;
   logic [REC_W-1:0]        bid_rec;
   logic [REC_W-1:0]        ask_rec;
   logic [31:0]             bid_lvl32;
   logic [31:0]             ask_lvl32;

   assign q_inst32 = 32'(q_cmd.instrument);
   assign q_lvl32  = 32'(q_cmd.price);
   assign q_inst   = q_inst32[IX_W-1:0];

   assign start    = (state_ff == ST_IDLE) && q_valid && (!rsp_valid_ff || rsp_pop);
   assign q_pop    = start;
   assign clearing = state_ff == ST_CLEAR;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   // Request decode against the side's current best.
   assign vol_nz  = vol_ff != '0;
   assign cur     = side_ff ? ask_rd_ff : bid_rd_ff;
   assign cur_lvl = cur[VOL_W +: LVL_W];
   assign lvl32   = 32'(lvl_ff);
   assign start_chunk32 = lvl32 / SCAN_CHUNK;

   always_comb begin
      new_row         = row_rd_ff;
      new_row[lvl_ff] = vol_nz;
      if (side_ff) begin
         take   = vol_nz && (cur[REC_W-1] || lvl_ff <= cur_lvl);
         rescan = !vol_nz && !cur[REC_W-1] && lvl_ff == cur_lvl;
      end else begin
         take   = vol_nz && lvl_ff >= cur_lvl;
         rescan = !vol_nz && lvl_ff == cur_lvl;
      end
   end

   // Search one chunk of the bitmap: below the removed level for bids,
   // above it for asks, nearest level first.
   assign row_pad    = PAD_W'(row_ff);
   assign chunk_bits = row_pad[chunk_ff * SCAN_CHUNK +: SCAN_CHUNK];
   assign hit_lvl    = hit_idx[LVL_W-1:0];
   assign last_chunk = side_ff ? (chunk_ff == CH_W'(NCHUNK - 1)) : (chunk_ff == '0);

   always_comb begin
      logic [31:0] idx;
      logic        cand;
      hit     = 1'b0;
      hit_idx = '0;
      for (int j = 0; j < SCAN_CHUNK; j++) begin
         idx  = 32'(chunk_ff) * SCAN_CHUNK + 32'(j);
         cand = chunk_bits[j] && (side_ff ? (idx > lvl32) : (idx < lvl32));
         if (cand && (!side_ff || !hit)) begin
            hit_idx = idx;
         end
         if (cand) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      row_in   = row_ff;
      chunk_in = chunk_ff;
      found_in = found_ff;
      finish   = 1'b0;
      best_we  = 1'b0;
      fin_rec  = cur;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == ROW_W'(ROWS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (kind_ff != KIND_UPDATE) begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else if (take) begin
               fin_rec  = {1'b0, lvl_ff, vol_ff};
               best_we  = 1'b1;
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else if (rescan) begin
               row_in   = new_row;
               chunk_in = start_chunk32[CH_W-1:0];
               state_in = ST_SCAN;
            end else begin
               finish   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (hit) begin
               found_in = hit_lvl;
               state_in = ST_VOL;
            end else if (last_chunk) begin
               fin_rec  = REC_RESET;
               best_we  = 1'b1;
               finish   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               chunk_in = side_ff ? chunk_ff + 1'b1 : chunk_ff - 1'b1;
            end
         end
         ST_VOL: begin
            fin_rec  = {1'b0, found_ff, vol_rd_ff};
            best_we  = 1'b1;
            finish   = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Result assembly.
   assign bid_rec   = side_ff ? bid_rd_ff : fin_rec;
   assign ask_rec   = side_ff ? fin_rec : ask_rd_ff;
   assign bid_lvl32 = 32'(bid_rec[VOL_W +: LVL_W]);
   assign ask_lvl32 = 32'(ask_rec[VOL_W +: LVL_W]);

   always_comb begin
      if (kind_ff == KIND_NULL) begin
         rsp_in.best_bid_price  = '0;
         rsp_in.best_bid_volume = '0;
         rsp_in.ask_empty       = 1'b1;
         rsp_in.best_ask_price  = '0;
         rsp_in.best_ask_volume = '0;
      end else begin
         rsp_in.best_bid_price  = bid_lvl32[PRICE_W-1:0];
         rsp_in.best_bid_volume = bid_rec[VOL_W-1:0];
         rsp_in.ask_empty       = ask_rec[REC_W-1];
         rsp_in.best_ask_price  = ask_lvl32[PRICE_W-1:0];
         rsp_in.best_ask_volume = ask_rec[VOL_W-1:0];
      end
   end

   assign rsp_valid_in = finish ? 1'b1 : (rsp_pop ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff   <= row_in;
      chunk_ff <= chunk_in;
      found_ff <= found_in;
      if (finish) begin
         rsp_ff <= rsp_in;
      end
      if (start) begin
         kind_ff <= q_cmd.kind;
         side_ff <= q_cmd.side;
         inst_ff <= q_inst;
         lvl_ff  <= q_lvl32[LVL_W-1:0];
         vol_ff  <= q_cmd.volume;
      end
   end

   // Memory reads, registered.
   always_ff @(posedge clock) begin
      if (start) begin
         row_rd_ff <= bmp_mem[{q_inst, q_cmd.side}];
         bid_rd_ff <= bid_mem[q_inst];
         ask_rd_ff <= ask_mem[q_inst];
      end
      if (state_ff == ST_SCAN && hit) begin
         vol_rd_ff <= vol_mem[{inst_ff, side_ff, hit_lvl}];
      end
   end

   // Volume store needs no clearing: an entry is read only when its bitmap
   // bit says it was written with a nonzero volume.
   always_ff @(posedge clock) begin
      if (state_ff == ST_READ && kind_ff == KIND_UPDATE) begin
         vol_mem[{inst_ff, side_ff, lvl_ff}] <= vol_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         bmp_mem[clr_ff] <= '0;
      end else if (state_ff == ST_READ && kind_ff == KIND_UPDATE) begin
         bmp_mem[{inst_ff, side_ff}] <= new_row;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR) begin
         bid_mem[clr_ff[ROW_W-1:1]] <= REC_RESET;
         ask_mem[clr_ff[ROW_W-1:1]] <= REC_RESET;
      end else if (best_we) begin
         if (side_ff) begin
            ask_mem[inst_ff] <= fin_rec;
         end else begin
            bid_mem[inst_ff] <= fin_rec;
         end
      end
   end

endmodule

// ===== hw/rtl/price_level_book_best_quote.sv =====
`timescale 1ns / 1ps
// When no search is needed, a request passes the front register, the command queue, the back end's
// command and read registers and the result register. The back end takes a new request only from idle,
// after the read-then-write sequence of the last one on the bitmap and best-quote memories.
// Removing the best level adds a search of SCAN_CHUNK bitmap bits per cycle, chunk by chunk
// outward from the removed level, then a volume read of the level found.
// After reset the block clears its bitmap and best quotes, req_full high.
// ----------------------------------------------------------------------------
// price_level_book_best_quote
// Per-instrument price-level book that reports best bid and best ask.
// ----------------------------------------------------------------------------
module price_level_book_best_quote import plbq_pkg::*; #(
   parameter int PRICE_LEVELS = DEF_PRICE_LEVELS,
   parameter int INSTRUMENTS  = DEF_INSTRUMENTS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_mode,
   input  logic [INST_W-1:0]  req_instrument,
   input  logic [PRICE_W-1:0] req_price,
   input  logic [VOL_W-1:0]   req_volume,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic [PRICE_W-1:0] rsp_best_bid_price,
   output logic [VOL_W-1:0]   rsp_best_bid_volume,
   output logic               rsp_ask_empty,
   output logic [PRICE_W-1:0] rsp_best_ask_price,
   output logic [VOL_W-1:0]   rsp_best_ask_volume
);

   logic    clearing;
   logic    q_full;
   logic    q_push;
   cmd_type q_in_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_out_cmd;
   logic    rsp_valid;
   rsp_type rsp;

   plbq_front #(
      .PRICE_LEVELS(PRICE_LEVELS),
      .INSTRUMENTS (INSTRUMENTS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_mode       (req_mode),
      .req_instrument (req_instrument),
      .req_price      (req_price),
      .req_volume     (req_volume),
      .clearing       (clearing),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_cmd          (q_in_cmd)
   );

   plbq_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .full     (q_full),
      .pop      (q_pop),
      .valid    (q_valid),
      .pop_cmd  (q_out_cmd)
   );

   plbq_back #(
      .PRICE_LEVELS(PRICE_LEVELS),
      .INSTRUMENTS (INSTRUMENTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_cmd     (q_out_cmd),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .rsp_pop   (rsp_pop),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_empty           = !rsp_valid;
   assign rsp_best_bid_price  = rsp.best_bid_price;
   assign rsp_best_bid_volume = rsp.best_bid_volume;
   assign rsp_ask_empty       = rsp.ask_empty;
   assign rsp_best_ask_price  = rsp.best_ask_price;
   assign rsp_best_ask_volume = rsp.best_ask_volume;

endmodule

// ===== hw/rtl/plbq_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plbq_checker
// Port-level checks on the price-level book, attached to the top level.
// ----------------------------------------------------------------------------
module plbq_checker import plbq_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_full,
   input logic               rsp_empty,
   input logic               rsp_pop,
   input logic [PRICE_W-1:0] rsp_best_bid_price,
   input logic [VOL_W-1:0]   rsp_best_bid_volume,
   input logic               rsp_ask_empty,
   input logic [PRICE_W-1:0] rsp_best_ask_price,
   input logic [VOL_W-1:0]   rsp_best_ask_volume
);

   // Reset leaves no result and starts the clearing pass.
   a_reset_state: assert property (@(posedge clock)
      reset |=> rsp_empty && req_full)
      else $error("result or request side open right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_best_bid_price)
         && $stable(rsp_best_bid_volume) && $stable(rsp_ask_empty)
         && $stable(rsp_best_ask_price) && $stable(rsp_best_ask_volume))
      else $error("waiting result changed");

   // An empty ask side reports zeros; a present one reports a real level.
   a_ask_quote: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_ask_empty == (rsp_best_ask_price == '0))
         && (rsp_ask_empty == (rsp_best_ask_volume == '0)))
      else $error("ask quote inconsistent with ask_empty");

   a_bid_quote: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((rsp_best_bid_price == '0) == (rsp_best_bid_volume == '0)))
      else $error("bid level and volume disagree");

endmodule

bind price_level_book_best_quote plbq_checker u_plbq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_full            (req_full),
   .rsp_empty           (rsp_empty),
   .rsp_pop             (rsp_pop),
   .rsp_best_bid_price  (rsp_best_bid_price),
   .rsp_best_bid_volume (rsp_best_bid_volume),
   .rsp_ask_empty       (rsp_ask_empty),
   .rsp_best_ask_price  (rsp_best_ask_price),
   .rsp_best_ask_volume (rsp_best_ask_volume)
);
